// ===== rtl/sa128_pkg.sv =====
package sa128_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;
  localparam logic [3:0] LastRound  = 4'd10;

  // state machine of the round sequencer
  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StRound = 2'b10
  } state_e;

  // status from the sequencer toward the lanes
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } lane_ctrl_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t sbox(byte_t x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = tbl[x];
  endfunction

  // byte i of a block sits at bits 127-8i .. 120-8i
  function automatic byte_t get_byte(block_t b, int i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

endpackage

// ===== rtl/sa128_if.sv =====
interface sa128_stream_if;
  logic   valid;
  logic   ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

interface sa128_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/shuffled_aes128_encrypt.sv =====
// AES-128 encryption of one 128-bit block per item.
// Channels: in_if carries plaintext (byte 0 in the top bits of data_high),
// out_if carries ciphertext in the same byte order, cfg_if writes the key:
// index 0 is key_high (key bytes 0..7), index 1 is key_low (bytes 8..15).
// Four column lanes compute one full round per cycle, save that the last round
// waits for the output register; the key lane makes the round key in the same
// cycle. An item takes a load step plus 10 rounds; the last round writes the
// ciphertext into the output register, and a new item is accepted only in idle.
// Reset clears the key to zero and empties the block; out valid is low.
// When the receiver stalls the ciphertext holds in the output register while
// the next item is accepted and runs its rounds; that item then waits in its
// last round until the output register is taken. Key writes are always
// accepted and take effect at the next accepted item.
module shuffled_aes128_encrypt (
  input  logic          clk_i,
  input  logic          rst_ni,
  sa128_stream_if.sink   in_if,
  sa128_stream_if.source out_if,
  sa128_cfg_if.sink      cfg_if
);
  sa128_pkg::state_e st_q, st_d;
  logic [3:0] rnd_q, rnd_d;
  logic [63:0] key_hi_q, key_lo_q;
  sa128_pkg::block_t blk_q, blk_d, res_q, res_d, rkey, rkey_next, round_out;
  logic res_vld_q, res_vld_d;
  sa128_pkg::lane_ctrl_t ctrl;
  logic in_acc;
  logic round_go;

  assign cfg_if.ready = 1'b1;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        sa128_pkg::RegKeyHigh: key_hi_q <= cfg_if.wdata;
        sa128_pkg::RegKeyLow:  key_lo_q <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  // a round advances unless the last one finds the output register full and not taken
  assign round_go = (st_q == sa128_pkg::StRound) &&
                    (!ctrl.last || !res_vld_q || out_if.ready);

  assign in_if.ready = (st_q == sa128_pkg::StIdle);
  assign in_acc = in_if.valid && in_if.ready;
  assign ctrl.load = in_acc;
  assign ctrl.step = round_go;
  assign ctrl.last = (rnd_q == sa128_pkg::LastRound);

  sa128_key_lane u_key (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .key_i      ({key_hi_q, key_lo_q}),
    .rkey_o     (rkey),
    .rkey_next_o(rkey_next)
  );

  // column lanes, merged into the next block
  for (genvar c = 0; c < 4; c++) begin : g_lane
    sa128_col_lane u_col (
      .state_i(blk_q),
      .col_i  (2'(c)),
      .last_i (ctrl.last),
      .rkey_i (rkey_next[127 - 32*c -: 32]),
      .col_o  (round_out[127 - 32*c -: 32])
    );
  end

  // round sequencer and output register
  always_comb begin
    st_d = st_q;
    rnd_d = rnd_q;
    blk_d = blk_q;
    res_d = res_q;
    res_vld_d = res_vld_q && !out_if.ready;
    case (st_q)
      sa128_pkg::StIdle: begin
        if (in_acc) begin
          blk_d = {in_if.data_high, in_if.data_low} ^ {key_hi_q, key_lo_q};
          rnd_d = 4'd1;
          st_d = sa128_pkg::StRound;
        end
      end
      sa128_pkg::StRound: begin
        if (round_go) begin
          blk_d = round_out;
          rnd_d = rnd_q + 4'd1;
          if (ctrl.last) begin
            res_d = round_out;
            res_vld_d = 1'b1;
            st_d = sa128_pkg::StIdle;
          end
        end
      end
      default: st_d = sa128_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sa128_pkg::StIdle;
      rnd_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rnd_q <= rnd_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    res_q <= res_d;
  end

  assign out_if.valid = res_vld_q;
  assign out_if.data_high = res_q[127:64];
  assign out_if.data_low = res_q[63:0];

  // checks
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("state not one-hot");
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_go && ctrl.last) |=> out_if.valid)
    else $error("no result after last round");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != sa128_pkg::StIdle) |-> !in_acc)
    else $error("item accepted while busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sa128_pkg::StRound) |-> (rnd_q != 4'd0 && rnd_q <= sa128_pkg::LastRound))
    else $error("round count out of range");
  a_key_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |=> rkey == $past(rkey_next))
    else $error("round key not advanced");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(res_q)))
    else $error("result changed while stalled");
endmodule

// ===== rtl/sa128_key_lane.sv =====
// key schedule: one round key per step
module sa128_key_lane (
  input  logic                   clk_i,
  input  sa128_pkg::lane_ctrl_t  ctrl_i,
  input  sa128_pkg::block_t      key_i,
  output sa128_pkg::block_t      rkey_o,
  output sa128_pkg::block_t      rkey_next_o
);
  sa128_pkg::block_t rk_q, rk_d;
  logic [7:0] rcon_q, rcon_d;
  logic [31:0] t;
  logic [31:0] w0, w1, w2, w3;

  // next key from the current one
  always_comb begin
    t = {sa128_pkg::sbox(sa128_pkg::get_byte(rk_q, 13)) ^ rcon_q,
         sa128_pkg::sbox(sa128_pkg::get_byte(rk_q, 14)),
         sa128_pkg::sbox(sa128_pkg::get_byte(rk_q, 15)),
         sa128_pkg::sbox(sa128_pkg::get_byte(rk_q, 12))};
    w0 = rk_q[127:96] ^ t;
    w1 = rk_q[95:64] ^ w0;
    w2 = rk_q[63:32] ^ w1;
    w3 = rk_q[31:0] ^ w2;
    rkey_next_o = {w0, w1, w2, w3};
  end

  always_comb begin
    rk_d = rk_q;
    rcon_d = rcon_q;
    if (ctrl_i.load) begin
      rk_d = key_i;
      rcon_d = 8'h01;
    end else if (ctrl_i.step) begin
      rk_d = rkey_next_o;
      rcon_d = sa128_pkg::xtime(rcon_q);
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
    rcon_q <= rcon_d;
  end

  assign rkey_o = rk_q;
endmodule

// ===== rtl/sa128_col_lane.sv =====
// one column lane: sbox, shift-row gather, mix column (skipped in the last round), key add
module sa128_col_lane (
  input  sa128_pkg::block_t     state_i,
  input  logic [1:0]            col_i,
  input  logic                  last_i,
  input  logic [31:0]           rkey_i,
  output logic [31:0]           col_o
);
  logic [7:0] a [4];
  logic [7:0] all;
  logic [31:0] mix;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      a[r] = sa128_pkg::sbox(sa128_pkg::get_byte(state_i,
               r + 4 * int'(2'(col_i + 2'(r)))));
    end
    all = a[0] ^ a[1] ^ a[2] ^ a[3];
    mix = {a[0] ^ all ^ sa128_pkg::xtime(a[0] ^ a[1]),
           a[1] ^ all ^ sa128_pkg::xtime(a[1] ^ a[2]),
           a[2] ^ all ^ sa128_pkg::xtime(a[2] ^ a[3]),
           a[3] ^ all ^ sa128_pkg::xtime(a[3] ^ a[0])};
    col_o = (last_i ? {a[0], a[1], a[2], a[3]} : mix) ^ rkey_i;
  end
endmodule

// ===== sim/tb.sv =====
module tb;

  logic clk_i;
  logic rst_ni;

  sa128_stream_if in_if ();
  sa128_stream_if out_if ();
  sa128_cfg_if    cfg_if ();

  shuffled_aes128_encrypt uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // aes-128 predictor, written from the standard definition
  function automatic sa128_pkg::byte_t gf_dbl(sa128_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic sa128_pkg::byte_t gf_mult(sa128_pkg::byte_t a, sa128_pkg::byte_t b);
    sa128_pkg::byte_t acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) acc = acc ^ a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  // inverse as x^254 then the affine map
  function automatic sa128_pkg::byte_t sub_b(sa128_pkg::byte_t x);
    sa128_pkg::byte_t p, inv, r;
    p = gf_mult(x, x);
    inv = p;
    for (int i = 0; i < 6; i++) begin
      p = gf_mult(p, p);
      inv = gf_mult(inv, p);
    end
    r = inv ^ 8'h63;
    for (int n = 1; n < 5; n++) r = r ^ ((inv << n) | (inv >> (8 - n)));
    return r;
  endfunction

  function automatic sa128_pkg::block_t aes_encrypt(sa128_pkg::block_t key,
                                                    sa128_pkg::block_t pt);
    sa128_pkg::byte_t s [16];
    sa128_pkg::byte_t k [16];
    sa128_pkg::byte_t t [16];
    sa128_pkg::byte_t tk [4];
    sa128_pkg::byte_t rc, all;
    sa128_pkg::block_t res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      s[i] = pt[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
      k[i] = key[127 - 8*i -: 8];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      tk[0] = sub_b(k[13]) ^ rc;
      tk[1] = sub_b(k[14]);
      tk[2] = sub_b(k[15]);
      tk[3] = sub_b(k[12]);
      for (int i = 0; i < 4; i++) k[i] = k[i] ^ tk[i];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
      rc = gf_dbl(rc);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r + 4*c] = sub_b(s[r + 4*((c + r) % 4)]);
      s = t;
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          for (int r = 0; r < 4; r++)
            s[4*c+r] = t[4*c+r] ^ all ^ gf_dbl(t[4*c+r] ^ t[4*c+((r+1)%4)]);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    return res;
  endfunction

  // pending ciphertexts and their check
  class cipher_board;
    sa128_pkg::block_t key;
    sa128_pkg::block_t pending[$];
    int     errors;

    function void note_plain(sa128_pkg::block_t pt);
      pending.push_back(aes_encrypt(key, pt));
    endfunction

    function void check_cipher(logic [63:0] hi, logic [63:0] lo);
      sa128_pkg::block_t exp_ct;
      if (pending.size() == 0) begin
        $error("ciphertext with no block pending: %h%h", hi, lo);
        errors++;
        return;
      end
      exp_ct = pending.pop_front();
      if (hi !== exp_ct[127:64]) begin
        $error("ciphertext_high expected %h actual %h", exp_ct[127:64], hi);
        errors++;
      end
      if (lo !== exp_ct[63:0]) begin
        $error("ciphertext_low expected %h actual %h", exp_ct[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  cipher_board board;
  int send_idle;
  int recv_stall;

  // receiver: random stalls, check at accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_cipher(out_if.data_high, out_if.data_low);
    out_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  // note accepted plaintexts
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_plain({in_if.data_high, in_if.data_low});
  end

  // valid stays high into the next item unless the sender idles
  task automatic send_plain(logic [127:0] pt);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_high <= pt[127:64];
    in_if.data_low  <= pt[63:0];
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == sa128_pkg::RegKeyHigh) board.key[127:64] = val;
    else board.key[63:0] = val;
    @(posedge clk_i);
  endtask

  task automatic set_key(logic [127:0] k);
    write_key(sa128_pkg::RegKeyHigh, k[127:64]);
    write_key(sa128_pkg::RegKeyLow, k[63:0]);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // stimulus
  initial begin
    board = new();
    board.key = '0;
    send_idle = 0;
    recv_stall = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_high = '0;
    in_if.data_low = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = sa128_pkg::RegKeyHigh;
    cfg_if.wdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key after reset
    send_plain('0);
    send_plain('1);
    send_plain(128'h00112233445566778899aabbccddeeff);
    wait_drained();

    // standard vector, then key extremes, then a second standard vector
    set_key(128'h000102030405060708090a0b0c0d0e0f);
    send_plain(128'h00112233445566778899aabbccddeeff);
    wait_drained();
    set_key('1);
    send_plain('0);
    send_plain('1);
    send_plain(128'h80000000000000000000000000000001);
    wait_drained();
    set_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_plain(128'h3243f6a8885a308d313198a2e0370734);
    send_plain(128'h55555555555555555555555555555555);
    send_plain(128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa);
    wait_drained();
    // only one half of the key changes
    write_key(sa128_pkg::RegKeyLow, '0);
    send_plain(rand_block());
    wait_drained();

    // random phases with varying idling and key changes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      set_key(rand_block());
      for (int n = 0; n < 55; n++) send_plain(rand_block());
      wait_drained();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sa128_pkg.sv
rtl/sa128_if.sv
rtl/sa128_key_lane.sv
rtl/sa128_col_lane.sv
rtl/shuffled_aes128_encrypt.sv
sim/tb.sv
